// ----- hw/rtl/lpmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmd_pkg: shared types and constants of the marker deframer
// Result codes, register indexes, the configuration bundle and the result
// bundle used by the deframer modules and channel interfaces.
// ----------------------------------------------------------------------------
package lpmd_pkg;

   // Frame layout.
   localparam int HEADER_BYTES     = 4;
   localparam int MARKER_MAX_BYTES = 8;

   localparam int HEADER_COUNT_W = $clog2(HEADER_BYTES);
   localparam int MARKER_IDX_W   = $clog2(MARKER_MAX_BYTES);

   // Field widths.
   localparam int BYTE_W       = 8;
   localparam int LENGTH_W     = 16;
   localparam int MARKER_W     = MARKER_MAX_BYTES * BYTE_W;
   localparam int MARKER_LEN_W = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;

   // Register reset values.
   localparam logic [LENGTH_W-1:0]     MAX_BODY_LENGTH_RESET = '1;
   localparam logic [MARKER_W-1:0]     MARKER_VALUE_RESET    = '0;
   localparam logic [MARKER_LEN_W-1:0] MARKER_LENGTH_RESET   = 4'd4;

   // Result codes.
   typedef enum logic [1:0] {
      KIND_BODY       = 2'd0,
      KIND_GOOD       = 2'd1,
      KIND_BAD_MARKER = 2'd2,
      KIND_BAD_LENGTH = 2'd3
   } kind_type;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_BODY_LENGTH = 2'd0,
      REG_MARKER_VALUE    = 2'd1,
      REG_MARKER_LENGTH   = 2'd2
   } reg_index_type;

   // Configuration seen by the deframer core.
   typedef struct packed {
      logic [LENGTH_W-1:0]     max_body_length;
      logic [MARKER_W-1:0]     marker_value;
      logic [MARKER_LEN_W-1:0] marker_length;
   } cfg_type;

   // One result item.
   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   body_byte;
      logic [LENGTH_W-1:0] frame_length;
   } result_type;

endpackage

// ----- hw/rtl/lpmd_req_if.sv -----
// ----------------------------------------------------------------------------
// lpmd_req_if: received byte channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface lpmd_req_if;
   logic                        valid;
   logic                        ready;
   logic [lpmd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/lpmd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lpmd_rsp_if: deframer result channel
// Valid/ready channel that carries body bytes and frame end status.
// ----------------------------------------------------------------------------
interface lpmd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    result_kind;
   logic [lpmd_pkg::BYTE_W-1:0]   body_byte;
   logic [lpmd_pkg::LENGTH_W-1:0] frame_length;

   modport source (output valid, output result_kind, output body_byte,
                   output frame_length, input ready);
   modport sink   (input valid, input result_kind, input body_byte,
                   input frame_length, output ready);
endinterface

// ----- hw/rtl/lpmd_csr_if.sv -----
// ----------------------------------------------------------------------------
// lpmd_csr_if: register write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface lpmd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lpmd_pkg::CSR_INDEX_W-1:0] index;
   logic [lpmd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/length_prefixed_marker_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_marker_deframer: byte stream deframer with end marker
// Parses frames made of a 4-byte little-endian signed length, the body and
// a configured end marker. Forwards body bytes and reports frame status.
//
//   Channel  Direction  Payload                                  Per item
//   req      in         rx_byte                                  one byte
//   rsp      out        result_kind, body_byte, frame_length     zero/one
//   csr      in         index, data                              one write
//
// One byte per clock while rsp takes results: a byte is held in the input
// register, parsed, and its result is loaded into the output register.
// The output register lets a new byte enter while a result waits.
// A stalled rsp blocks only bytes that produce a result.
// Reset is synchronous and returns to the header phase with default
// registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_marker_deframer (
   input  logic       clock,
   input  logic       reset,
   lpmd_req_if.sink   req,
   lpmd_rsp_if.source rsp,
   lpmd_csr_if.sink   csr
);

   lpmd_pkg::cfg_type    cfg;
   lpmd_pkg::result_type result;
   logic                 out_free;
   logic                 load;

   // Configuration registers.
   lpmd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // Input register and parser.
   lpmd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .out_free (out_free),
      .load     (load),
      .result   (result)
   );

   // Output register.
   lpmd_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // The parser never overwrites a result that is still waiting.
   a_load_has_room: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded into a full output register");

   // A loaded result is shown on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp.valid)
      else $error("loaded result not presented");

   // Only body items carry a data byte.
   a_body_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.result_kind != 2'(lpmd_pkg::KIND_BODY))
      |-> (rsp.body_byte == '0))
      else $error("status item with a nonzero body byte");

   // Body and length-error items report no frame length.
   a_length_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.result_kind == 2'(lpmd_pkg::KIND_BODY)
                  || rsp.result_kind == 2'(lpmd_pkg::KIND_BAD_LENGTH)))
      |-> (rsp.frame_length == '0))
      else $error("frame length reported on a body or length-error item");
`endif

endmodule

// ----- hw/rtl/lpmd_csr.sv -----
// ----------------------------------------------------------------------------
// lpmd_csr: deframer configuration registers
// Holds the maximum body length, marker bytes and marker length. Writes
// are always taken; an unknown index is dropped.
// ----------------------------------------------------------------------------
module lpmd_csr (
   input  logic                 clock,
   input  logic                 reset,
   lpmd_csr_if.sink             csr,
   output lpmd_pkg::cfg_type    cfg
);

   lpmd_pkg::cfg_type cfg_ff;
   lpmd_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write index into the matching register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (lpmd_pkg::reg_index_type'(csr.index))
            lpmd_pkg::REG_MAX_BODY_LENGTH: begin
               cfg_in.max_body_length = csr.data[lpmd_pkg::LENGTH_W-1:0];
            end
            lpmd_pkg::REG_MARKER_VALUE: begin
               cfg_in.marker_value = csr.data[lpmd_pkg::MARKER_W-1:0];
            end
            lpmd_pkg::REG_MARKER_LENGTH: begin
               cfg_in.marker_length = csr.data[lpmd_pkg::MARKER_LEN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_body_length <= lpmd_pkg::MAX_BODY_LENGTH_RESET;
         cfg_ff.marker_value    <= lpmd_pkg::MARKER_VALUE_RESET;
         cfg_ff.marker_length   <= lpmd_pkg::MARKER_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/lpmd_core.sv -----
// ----------------------------------------------------------------------------
// lpmd_core: input register and frame parser
// Registers each received byte, then parses it in the current header, body
// or marker phase. It hands a result to the output stage when the byte
// produces one and advances only when that stage can take it.
// ----------------------------------------------------------------------------
module lpmd_core (
   input  logic                    clock,
   input  logic                    reset,
   lpmd_req_if.sink                req,
   input  lpmd_pkg::cfg_type       cfg,
   input  logic                    out_free,
   output logic                    load,
   output lpmd_pkg::result_type    result
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_MARKER = 2'd2
   } phase_type;

   localparam int HCW = lpmd_pkg::HEADER_COUNT_W;
   localparam int LW  = lpmd_pkg::LENGTH_W;
   localparam int BW  = lpmd_pkg::BYTE_W;
   localparam int SW  = (lpmd_pkg::HEADER_BYTES - 1) * lpmd_pkg::BYTE_W;
   localparam int MLW = lpmd_pkg::MARKER_LEN_W;
   localparam logic [HCW-1:0] HEADER_LAST = HCW'(lpmd_pkg::HEADER_BYTES - 1);
   localparam logic [MLW-1:0] MARKER_MAX  = MLW'(lpmd_pkg::MARKER_MAX_BYTES);

   // Input register.
   logic          in_valid_ff;
   logic [BW-1:0] in_byte_ff;

   // Parser state.
   phase_type      phase_ff,           phase_in;
   logic [SW-1:0]  header_shift_ff,    header_shift_in;
   logic [HCW-1:0] header_count_ff,    header_count_in;
   logic [LW-1:0]  body_length_ff,     body_length_in;
   logic [LW-1:0]  body_remaining_ff,  body_remaining_in;
   logic [MLW-1:0] marker_index_ff,    marker_index_in;
   logic           marker_mismatch_ff, marker_mismatch_in;

   logic                              emit;
   logic                              advance;
   logic [MLW-1:0]                    marker_len_eff;
   logic [BW-1:0]                     marker_byte;
   logic [lpmd_pkg::MARKER_IDX_W-1:0] marker_sel;
   logic [SW+BW-1:0]                  header_raw;
   logic                              length_bad;

   // The stage moves when it has a byte and any result it makes has room.
   assign advance   = in_valid_ff && (!emit || out_free);
   assign load      = advance && emit;
   assign req.ready = !in_valid_ff || advance;

   // Marker length clamped to one through the maximum.
   always_comb begin
      if (cfg.marker_length == '0) begin
         marker_len_eff = MLW'(1);
      end else if (cfg.marker_length > MARKER_MAX) begin
         marker_len_eff = MARKER_MAX;
      end else begin
         marker_len_eff = cfg.marker_length;
      end
   end

   assign marker_sel  = marker_index_ff[lpmd_pkg::MARKER_IDX_W-1:0];
   assign marker_byte = cfg.marker_value[{marker_sel, 3'b000} +: BW];

   // Full header with the last byte in the top position.
   assign header_raw = {in_byte_ff, header_shift_ff};
   assign length_bad = header_raw[SW+BW-1]
                    || (header_raw[SW+BW-2:LW] != '0)
                    || (header_raw[LW-1:0] > cfg.max_body_length);

   // One parsing step for the registered byte.
   always_comb begin
      phase_in           = phase_ff;
      header_shift_in    = header_shift_ff;
      header_count_in    = header_count_ff;
      body_length_in     = body_length_ff;
      body_remaining_in  = body_remaining_ff;
      marker_index_in    = marker_index_ff;
      marker_mismatch_in = marker_mismatch_ff;
      emit               = 1'b0;
      result             = '0;
      result.kind        = lpmd_pkg::KIND_BODY;

      case (phase_ff)
         PH_BODY: begin
            emit              = 1'b1;
            result.kind       = lpmd_pkg::KIND_BODY;
            result.body_byte  = in_byte_ff;
            body_remaining_in = body_remaining_ff - LW'(1);
            if (body_remaining_in == '0) begin
               phase_in           = PH_MARKER;
               marker_index_in    = '0;
               marker_mismatch_in = 1'b0;
            end
         end
         PH_MARKER: begin
            marker_mismatch_in = marker_mismatch_ff || (in_byte_ff != marker_byte);
            marker_index_in    = marker_index_ff + MLW'(1);
            if (marker_index_in >= marker_len_eff) begin
               // Last marker byte: report and start over.
               emit                = 1'b1;
               result.kind         = marker_mismatch_in ? lpmd_pkg::KIND_BAD_MARKER
                                                        : lpmd_pkg::KIND_GOOD;
               result.frame_length = body_length_ff;
               phase_in            = PH_HEADER;
               header_shift_in     = '0;
               header_count_in     = '0;
               body_length_in      = '0;
               body_remaining_in   = '0;
               marker_index_in     = '0;
               marker_mismatch_in  = 1'b0;
            end
         end
         default: begin
            // Header phase, also taken for the unused phase code.
            phase_in = PH_HEADER;
            if (header_count_ff == HEADER_LAST) begin
               header_shift_in    = '0;
               header_count_in    = '0;
               marker_index_in    = '0;
               marker_mismatch_in = 1'b0;
               if (length_bad) begin
                  emit              = 1'b1;
                  result.kind       = lpmd_pkg::KIND_BAD_LENGTH;
                  body_length_in    = '0;
                  body_remaining_in = '0;
               end else begin
                  body_length_in    = header_raw[LW-1:0];
                  body_remaining_in = header_raw[LW-1:0];
                  phase_in = (header_raw[LW-1:0] == '0) ? PH_MARKER : PH_BODY;
               end
            end else begin
               header_shift_in = header_shift_ff
                               | (SW'(in_byte_ff) << {header_count_ff, 3'b000});
               header_count_in = header_count_ff + HCW'(1);
            end
         end
      endcase
   end

   // Input register and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         phase_ff           <= PH_HEADER;
         header_shift_ff    <= '0;
         header_count_ff    <= '0;
         body_length_ff     <= '0;
         body_remaining_ff  <= '0;
         marker_index_ff    <= '0;
         marker_mismatch_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            phase_ff           <= phase_in;
            header_shift_ff    <= header_shift_in;
            header_count_ff    <= header_count_in;
            body_length_ff     <= body_length_in;
            body_remaining_ff  <= body_remaining_in;
            marker_index_ff    <= marker_index_in;
            marker_mismatch_ff <= marker_mismatch_in;
         end
      end
   end

   // Byte data needs no reset.
   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.rx_byte;
      end
   end

endmodule

// ----- hw/rtl/lpmd_out.sv -----
// ----------------------------------------------------------------------------
// lpmd_out: result output register
// Holds one result item until the consumer takes it and reports when it
// can take the next one.
// ----------------------------------------------------------------------------
module lpmd_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lpmd_pkg::result_type    result,
   output logic                    out_free,
   lpmd_rsp_if.source              rsp
);

   logic                 valid_ff;
   lpmd_pkg::result_type result_ff;

   // Free when empty or when the held item leaves this cycle.
   assign out_free = !valid_ff || rsp.ready;

   assign rsp.valid        = valid_ff;
   assign rsp.result_kind  = 2'(result_ff.kind);
   assign rsp.body_byte    = result_ff.body_byte;
   assign rsp.frame_length = result_ff.frame_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule
